### hw/rtl/gauss_seidel_stencil_relax_macros.svh
// Assertion helpers for the relaxation engine.
`ifndef GAUSS_SEIDEL_STENCIL_RELAX_MACROS_SVH
`define GAUSS_SEIDEL_STENCIL_RELAX_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define GSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an implication holds in the cycle after its antecedent.
`define GSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gsr_pkg.sv
package gsr_pkg;

    // Input actions.
    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_RUN   = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    // Configuration register indexes.
    localparam logic CFG_GRID_SIZE   = 1'b0;
    localparam logic CFG_SWEEP_COUNT = 1'b1;

    localparam int CHANGE_WIDTH = 47;
    localparam int FRAC_BITS    = 16;
    localparam int COEF_03      = 19661;

endpackage

### hw/rtl/gauss_seidel_stencil_relax.sv
// Gauss-Seidel five-point relaxation engine over a (GRID_MAX+1)^2 grid of signed Q16.16
// values held in one synchronous RAM; n below is the configured grid size clamped to
// GRID_MAX. A write beat finishes in the cycle that it is taken; a read beat passes
// through the RAM read, then the result register. Init walks every cell of rows and
// columns 0..n. In a run, each interior cell of each sweep reads its four neighbors
// and then itself through the single read port, forms the rounded product and writes
// it back. A run with a sweep count of zero or with n below 2 updates no cell. The
// left neighbor is written in the cycle before its read is issued, so it is already
// in the RAM and needs no forwarding.
// A new beat is taken only while the engine is idle and the result register is empty
// or being emptied in the same cycle, so one beat is in flight at a time.
module gauss_seidel_stencil_relax #(
    parameter int GRID_MAX    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [15:0]                          i_cfg_data,
    // Input channel.
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_action,
    input  logic [8:0]                           i_row,
    input  logic [8:0]                           i_col,
    input  logic signed [VALUE_WIDTH-1:0]        i_cell_in,
    // Output channel.
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [VALUE_WIDTH-1:0]        o_cell_out,
    output logic [gsr_pkg::CHANGE_WIDTH-1:0]     o_sweep_change,
    output logic                                 o_saturated
);

    localparam int SIDE   = GRID_MAX + 1;
    localparam int DEPTH  = SIDE * SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int IW     = $clog2(SIDE);
    localparam int CW     = gsr_pkg::CHANGE_WIDTH;
    localparam int SUMW   = VALUE_WIDTH + 3;
    localparam int PRODW  = SUMW + 16;
    localparam logic [CW-1:0] CHANGE_MAX = {CW{1'b1}};
    localparam logic signed [PRODW-1:0] VMAX_P =
        PRODW'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    localparam logic signed [PRODW-1:0] VMIN_P =
        -VMAX_P - PRODW'(1);
    localparam logic [AW-1:0] SIDE_A = AW'(SIDE);

    // One-hot sequencer.
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_INIT  = 10'b0000000010,
        S_READ  = 10'b0000000100,
        S_RD_C  = 10'b0000001000,
        S_RD_L  = 10'b0000010000,
        S_RD_U  = 10'b0000100000,
        S_RD_R  = 10'b0001000000,
        S_RD_D  = 10'b0010000000,
        S_CALC  = 10'b0100000000,
        S_WRITE = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [8:0]  r_grid_size;
    logic [15:0] r_sweep_count;
    logic [IW-1:0] r_n, r_i, r_j;
    logic [15:0] r_sweep;
    logic [CW-1:0] r_acc, r_last_change;
    logic r_ovf;
    logic signed [SUMW-1:0] r_sum;
    logic signed [VALUE_WIDTH-1:0] r_old;
    logic signed [PRODW-1:0] r_prod;

    logic r_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_cell_out;
    logic r_read_range;

    // RAM ports.
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

    gsr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic in_acc, out_free, in_range;
    logic [AW-1:0] cell_addr;
    logic [IW:0] clamp_n;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !(r_state == S_IDLE) || !out_free;
    assign in_acc   = i_valid && !o_stall;
    assign in_range = (int'(i_row) <= GRID_MAX) && (int'(i_col) <= GRID_MAX);
    assign clamp_n  = (int'(r_grid_size) > GRID_MAX) ? (IW+1)'(GRID_MAX)
                                                    : (IW+1)'(r_grid_size);
    assign cell_addr = AW'(r_i) * SIDE_A + AW'(r_j);

    // Saturated update value and its distance from the old value.
    logic signed [PRODW-1:0] rounded;
    logic signed [VALUE_WIDTH-1:0] new_val;
    logic new_sat;
    logic signed [VALUE_WIDTH:0] diff;
    logic [CW:0] acc_sum;
    logic [CW-1:0] acc_sat;

    always_comb begin
        rounded = r_prod >>> 16;
        new_sat = 1'b0;
        if (rounded > VMAX_P) begin
            new_val = VMAX_P[VALUE_WIDTH-1:0];
            new_sat = 1'b1;
        end else if (rounded < VMIN_P) begin
            new_val = VMIN_P[VALUE_WIDTH-1:0];
            new_sat = 1'b1;
        end else begin
            new_val = rounded[VALUE_WIDTH-1:0];
        end
        diff = (VALUE_WIDTH+1)'(new_val) - (VALUE_WIDTH+1)'(r_old);
        if (diff < 0) begin
            diff = -diff;
        end
        acc_sum = (CW+1)'(r_acc) + (CW+1)'(unsigned'(diff));
        acc_sat = (acc_sum > (CW+1)'(CHANGE_MAX)) ? CHANGE_MAX : acc_sum[CW-1:0];
    end

    // RAM address and write selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cell_addr;
        ram_wdata = '0;
        ram_raddr = cell_addr;
        if (in_acc && i_action == gsr_pkg::ACT_WRITE && in_range) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(i_row) * SIDE_A + AW'(i_col);
            ram_wdata = i_cell_in;
        end
        if (in_acc) begin
            ram_raddr = AW'(i_row) * SIDE_A + AW'(i_col);
        end
        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = (r_i == '0 || r_j == '0) ?
                            VALUE_WIDTH'(32'h0001_0000) : '0;
            end
            S_RD_C:  ram_raddr = cell_addr - AW'(1);
            S_RD_L:  ram_raddr = cell_addr - SIDE_A;
            S_RD_U:  ram_raddr = cell_addr + AW'(1);
            S_RD_R:  ram_raddr = cell_addr + SIDE_A;
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_wdata = new_val;
            end
            default: ;
        endcase
    end

    // Sequencer.
    logic done_point, last_j, last_i, run_end, run_skip, out_done;
    assign last_j   = (r_j == r_n - IW'(1));
    assign last_i   = (r_i == r_n - IW'(1));
    assign run_end  = last_j && last_i && (r_sweep + 16'd1 == r_sweep_count);
    assign run_skip = (r_sweep_count == '0) || (clamp_n < (IW+1)'(2));

    // A result is ready once its beat has finished.
    assign out_done =
        (in_acc && (i_action == gsr_pkg::ACT_WRITE ||
                    (i_action == gsr_pkg::ACT_RUN && run_skip))) ||
        (r_state == S_INIT && r_j == r_n && r_i == r_n) ||
        (r_state == S_READ) ||
        (r_state == S_WRITE && run_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_grid_size   <= 9'd256;
            r_sweep_count <= 16'd100;
            r_last_change <= '0;
            r_ovf         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == gsr_pkg::CFG_GRID_SIZE) begin
                    r_grid_size <= i_cfg_data[8:0];
                end else begin
                    r_sweep_count <= i_cfg_data;
                end
            end
            if (out_done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cell_out   <= '0;
                        r_read_range <= in_range;
                        r_i          <= (i_action == gsr_pkg::ACT_RUN) ? IW'(1) : '0;
                        r_j          <= (i_action == gsr_pkg::ACT_RUN) ? IW'(1) : '0;
                        r_n          <= clamp_n[IW-1:0];
                        unique case (i_action)
                            gsr_pkg::ACT_INIT: r_state <= S_INIT;
                            gsr_pkg::ACT_READ: r_state <= S_READ;
                            gsr_pkg::ACT_RUN: begin
                                r_last_change <= '0;
                                r_ovf         <= 1'b0;
                                r_sweep       <= '0;
                                r_acc         <= '0;
                                if (!run_skip) begin
                                    r_state <= S_RD_C;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_INIT: begin
                    if (r_j == r_n) begin
                        r_j <= '0;
                        if (r_i == r_n) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + IW'(1);
                        end
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                S_READ: begin
                    r_cell_out <= r_read_range ? ram_rdata : '0;
                    r_state    <= S_IDLE;
                end
                S_RD_C: r_state <= S_RD_L;
                S_RD_L: begin
                    // Left neighbor, already updated in this sweep.
                    r_sum   <= SUMW'(signed'(ram_rdata));
                    r_state <= S_RD_U;
                end
                S_RD_U: begin
                    r_sum   <= r_sum + SUMW'(signed'(ram_rdata));
                    r_state <= S_RD_R;
                end
                S_RD_R: begin
                    r_sum   <= r_sum + SUMW'(signed'(ram_rdata));
                    r_state <= S_RD_D;
                end
                S_RD_D: begin
                    r_sum   <= r_sum + SUMW'(signed'(ram_rdata));
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    // The cell itself arrives last.
                    r_old   <= ram_rdata;
                    r_prod  <= (PRODW'(r_sum) + PRODW'(signed'(ram_rdata)))
                               * PRODW'(gsr_pkg::COEF_03) + PRODW'(32768);
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (new_sat) begin
                        r_ovf <= 1'b1;
                    end
                    r_acc   <= (last_j && last_i) ? '0 : acc_sat;
                    r_state <= run_end ? S_IDLE : S_RD_C;
                    if (last_j) begin
                        r_j <= IW'(1);
                        if (last_i) begin
                            r_i           <= IW'(1);
                            r_last_change <= acc_sat;
                            r_sweep       <= r_sweep + 16'd1;
                        end else begin
                            r_i <= r_i + IW'(1);
                        end
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A cell write that is not the last of its row.
    assign done_point = (r_state == S_WRITE) && !last_j;
    assign o_valid        = r_out_valid;
    assign o_cell_out     = r_cell_out;
    assign o_sweep_change = r_last_change;
    assign o_saturated    = r_ovf;

    `include "gauss_seidel_stencil_relax_macros.svh"

    `GSR_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !in_acc, "busy accept")
    `GSR_ASSERT_NEXT(a_row_next, i_clk, i_rst_n, done_point, r_state == S_RD_C, "row stalled")
    `GSR_ASSERT_IMP(a_busy_quiet, i_clk, i_rst_n, r_state != S_IDLE, !r_out_valid, "busy result")

endmodule

### hw/rtl/gsr_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module gsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SIDE_MAX   = 256;
    localparam int RUN_LIMIT  = 5_000_000;
    localparam longint VMAX   = 64'sd2147483647;
    localparam longint VMIN   = -64'sd2147483648;
    localparam longint unsigned CHG_MAX = (64'd1 << 47) - 1;

    typedef struct packed {
        logic signed [31:0] cell_val;
        logic [46:0]        change;
        logic               sat;
    } t_result;

    typedef struct {
        bit                 is_cfg;
        logic               cfg_idx;
        logic [15:0]        cfg_val;
        logic [1:0]         act;
        logic [8:0]         row;
        logic [8:0]         col;
        logic signed [31:0] val;
        bit                 typed;
        t_result            want;
    } t_step;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_action = '0;
    logic [8:0]         i_row = '0;
    logic [8:0]         i_col = '0;
    logic signed [31:0] i_cell_in = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_cell_out;
    logic [46:0]        o_sweep_change;
    logic               o_saturated;

    gauss_seidel_stencil_relax dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the grid and the engine state.
    logic signed [31:0] grid [0:SIDE_MAX][0:SIDE_MAX];
    logic [46:0]        held_change = '0;
    logic               held_sat = 1'b0;
    int unsigned        size_reg = 256;
    int unsigned        sweeps_reg = 100;

    t_result result_q[$];
    t_step   plan_q[$];
    int      errors = 0;
    int      cycles = 0;
    bit      calm = 1'b0;

    function automatic void relax_grid();
        int unsigned n;
        longint sum, v, old;
        longint unsigned acc;
        n = (size_reg > SIDE_MAX) ? SIDE_MAX : size_reg;
        held_change = '0;
        held_sat = 1'b0;
        for (int unsigned s = 0; s < sweeps_reg; s++) begin
            acc = 0;
            for (int i = 1; i < int'(n); i++) begin
                for (int j = 1; j < int'(n); j++) begin
                    old = grid[i][j];
                    sum = old + grid[i][j-1] + grid[i-1][j] + grid[i][j+1] + grid[i+1][j];
                    // Rounded product with 0.3, then clamp to the value range.
                    v = (sum * gsr_pkg::COEF_03 + 32768) >>> gsr_pkg::FRAC_BITS;
                    if (v > VMAX) begin
                        v = VMAX;
                        held_sat = 1'b1;
                    end else if (v < VMIN) begin
                        v = VMIN;
                        held_sat = 1'b1;
                    end
                    grid[i][j] = 32'(v);
                    acc += (v >= old) ? longint'(v - old) : longint'(old - v);
                    if (acc > CHG_MAX) acc = CHG_MAX;
                end
            end
            held_change = 47'(acc);
        end
    endfunction

    function automatic t_result apply_beat(t_step b);
        t_result r;
        int unsigned n;
        bit ok;
        r = '0;
        ok = (b.row <= SIDE_MAX) && (b.col <= SIDE_MAX);
        n = (size_reg > SIDE_MAX) ? SIDE_MAX : size_reg;
        case (b.act)
            gsr_pkg::ACT_INIT: begin
                for (int i = 0; i <= int'(n); i++)
                    for (int j = 0; j <= int'(n); j++)
                        grid[i][j] = (i == 0 || j == 0) ? 32'sd65536 : 32'sd0;
            end
            gsr_pkg::ACT_WRITE: begin
                if (ok) grid[b.row][b.col] = b.val;
            end
            gsr_pkg::ACT_RUN: relax_grid();
            default: begin
                if (ok) r.cell_val = grid[b.row][b.col];
            end
        endcase
        r.change = held_change;
        r.sat = held_sat;
        return r;
    endfunction

    // Plan builders.
    task automatic add_beat(gsr_pkg::t_action a, int r, int c, logic signed [31:0] v);
        t_step s;
        s = '{default: '0};
        s.act = a;
        s.row = 9'(r);
        s.col = 9'(c);
        s.val = v;
        plan_q.push_back(s);
    endtask

    task automatic add_known(gsr_pkg::t_action a, int r, int c, logic signed [31:0] v,
                             logic signed [31:0] cell_val, logic [46:0] chg, logic sat);
        add_beat(a, r, c, v);
        plan_q[$].typed = 1'b1;
        plan_q[$].want = '{cell_val, chg, sat};
    endtask

    task automatic add_cfg(logic idx, int val);
        t_step s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.cfg_idx = idx;
        s.cfg_val = 16'(val);
        plan_q.push_back(s);
    endtask

    // Wait until every result is back and the engine has gone quiet.
    task automatic drain();
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == gsr_pkg::CFG_GRID_SIZE) size_reg = val & 16'h1FF;
        else sweeps_reg = val;
    endtask

    // Offer one beat, hold it until taken, then record what it should produce.
    task automatic send_beat(t_step b);
        t_result r;
        while (!calm && $urandom_range(0, 99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= b.act;
        i_row <= b.row;
        i_col <= b.col;
        i_cell_in <= b.val;
        do @(posedge i_clk); while (o_stall);
        r = apply_beat(b);
        result_q.push_back(b.typed ? b.want : r);
    endtask

    task automatic run_step(t_step s);
        if (s.is_cfg) write_reg(s.cfg_idx, s.cfg_val);
        else send_beat(s);
    endtask

    // Output side: random stall and comparison against the oldest expectation.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat: cell %h", o_cell_out);
            end else begin
                e = result_q.pop_front();
                if (o_cell_out !== e.cell_val || o_sweep_change !== e.change ||
                    o_saturated !== e.sat) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: cell %h/%h change %h/%h sat %b/%b (exp/act)",
                                 e.cell_val, o_cell_out, e.change, o_sweep_change,
                                 e.sat, o_saturated);
                end
            end
        end
        i_stall <= !calm && ($urandom_range(0, 99) < 16);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int n, r, pick;
        t_step s;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: full-size init first so that every cell is defined.
        add_known(gsr_pkg::ACT_INIT, 0, 0, 0, 0, 0, 0);
        add_known(gsr_pkg::ACT_READ, 0, 0, 0, 32'sd65536, 0, 0);
        add_known(gsr_pkg::ACT_READ, 256, 256, 0, 0, 0, 0);
        add_known(gsr_pkg::ACT_READ, 0, 256, 0, 32'sd65536, 0, 0);
        add_known(gsr_pkg::ACT_READ, 257, 3, 0, 0, 0, 0);
        add_known(gsr_pkg::ACT_READ, 511, 511, 0, 0, 0, 0);
        add_known(gsr_pkg::ACT_WRITE, 511, 0, 32'h12345678, 0, 0, 0);
        add_known(gsr_pkg::ACT_WRITE, 100, 100, 32'h7FFFFFFF, 0, 0, 0);
        add_known(gsr_pkg::ACT_READ, 100, 100, 0, 32'h7FFFFFFF, 0, 0);
        add_known(gsr_pkg::ACT_WRITE, 100, 101, 32'h80000000, 0, 0, 0);
        add_known(gsr_pkg::ACT_READ, 100, 101, 0, 32'h80000000, 0, 0);
        add_cfg(gsr_pkg::CFG_SWEEP_COUNT, 0);
        add_known(gsr_pkg::ACT_RUN, 0, 0, 0, 0, 0, 0);
        add_cfg(gsr_pkg::CFG_GRID_SIZE, 2);
        add_cfg(gsr_pkg::CFG_SWEEP_COUNT, 65535);
        add_beat(gsr_pkg::ACT_INIT, 0, 0, 0);
        add_beat(gsr_pkg::ACT_WRITE, 1, 2, 32'h7FFFFFFF);
        add_beat(gsr_pkg::ACT_WRITE, 2, 1, 32'h7FFFFFFF);
        add_beat(gsr_pkg::ACT_RUN, 0, 0, 0);
        add_beat(gsr_pkg::ACT_READ, 1, 1, 0);
        add_cfg(gsr_pkg::CFG_GRID_SIZE, 1);
        add_known(gsr_pkg::ACT_RUN, 0, 0, 0, 0, 0, 0);
        add_cfg(gsr_pkg::CFG_GRID_SIZE, 0);
        add_known(gsr_pkg::ACT_RUN, 0, 0, 0, 0, 0, 0);
        add_cfg(gsr_pkg::CFG_GRID_SIZE, 511);
        add_cfg(gsr_pkg::CFG_SWEEP_COUNT, 0);
        add_known(gsr_pkg::ACT_RUN, 0, 0, 0, 0, 0, 0);
        foreach (plan_q[k]) run_step(plan_q[k]);

        // Random part: small grids, short runs, mixed cell traffic.
        for (int ph = 0; ph < 5; ph++) begin
            calm = (ph == 2);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
            write_reg(gsr_pkg::CFG_GRID_SIZE, 16'(n));
            write_reg(gsr_pkg::CFG_SWEEP_COUNT, 16'($urandom_range(0, 12)));
            s = '{default: '0};
            s.act = gsr_pkg::ACT_INIT;
            send_beat(s);
            for (int k = 0; k < 100; k++) begin
                s = '{default: '0};
                pick = $urandom_range(0, 99);
                r = $urandom_range(0, 3);
                if (r == 0) begin
                    s.row = 9'($urandom_range(0, 511));
                    s.col = 9'($urandom_range(0, 511));
                end else begin
                    s.row = 9'($urandom_range(0, n));
                    s.col = 9'($urandom_range(0, n));
                end
                if ($urandom_range(0, 1) == 0) s.val = $urandom();
                else s.val = 32'($signed($urandom_range(0, 262143)) - 131072);
                if (pick < 40) s.act = gsr_pkg::ACT_WRITE;
                else if (pick < 78) s.act = gsr_pkg::ACT_READ;
                else if (pick < 94) s.act = gsr_pkg::ACT_RUN;
                else s.act = gsr_pkg::ACT_INIT;
                send_beat(s);
            end
        end
        calm = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
